// ----- design/fehs_pkg.sv -----
// ----------------------------------------------------------------------------
// fehs_pkg: shared types and constants of the fire heat spread block
// Field widths, codes, the back-end state type, the command word carried
// between front and back, and the flame palette.
// ----------------------------------------------------------------------------
package fehs_pkg;

    localparam int CFG_W    = 9;
    localparam int COORD_W  = 8;
    localparam int OFF_W    = 2;
    localparam int HEAT_W   = 5;
    localparam int COLOUR_W = 8;
    localparam int PROD_W   = 17;
    localparam int AREA_W   = 18;
    localparam int CALC_W   = 19;

    localparam logic [HEAT_W-1:0] COLD_HEAT  = 5'd19;
    localparam logic [HEAT_W-1:0] HOT_HEAT   = 5'd0;
    localparam logic [OFF_W-1:0]  MAX_OFFSET = 2'd2;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 9'd256;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 9'd256;

    typedef enum logic [0:0] {
        OP_SPREAD = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_ACCESS
    } back_state_t;

    typedef struct packed {
        logic              in_image;
        logic              spread;
        logic              bottom;
        logic [OFF_W-1:0]  off;
        logic [CALC_W-1:0] src;
        logic [CALC_W-1:0] up;
        logic [CALC_W-1:0] dst;
        logic              dst_ok;
    } cmd_t;

    typedef struct packed {
        logic clearing;
        logic res_push;
        logic res_full;
    } back_status_t;

    function automatic logic [3*COLOUR_W-1:0] palette(input logic [HEAT_W-1:0] h);
        logic [3*COLOUR_W-1:0] rgb;
        case (h)
            5'd0:    rgb = {8'd83,  8'd141, 8'd214};
            5'd1:    rgb = {8'd140, 8'd179, 8'd228};
            5'd2:    rgb = {8'd197, 8'd217, 8'd241};
            5'd3:    rgb = {8'd226, 8'd236, 8'd248};
            5'd4:    rgb = {8'd255, 8'd255, 8'd255};
            5'd5:    rgb = {8'd255, 8'd255, 8'd229};
            5'd6:    rgb = {8'd255, 8'd255, 8'd202};
            5'd7:    rgb = {8'd255, 8'd255, 8'd102};
            5'd8:    rgb = {8'd254, 8'd255, 8'd1};
            5'd9:    rgb = {8'd255, 8'd224, 8'd1};
            5'd10:   rgb = {8'd255, 8'd192, 8'd0};
            5'd11:   rgb = {8'd254, 8'd96,  8'd1};
            5'd12:   rgb = {8'd253, 8'd0,   8'd2};
            5'd13:   rgb = {8'd223, 8'd96,  8'd97};
            5'd14:   rgb = {8'd192, 8'd192, 8'd192};
            5'd15:   rgb = {8'd128, 8'd128, 8'd128};
            5'd16:   rgb = {8'd64,  8'd64,  8'd64};
            5'd17:   rgb = {8'd32,  8'd32,  8'd32};
            default: rgb = {8'd0,   8'd0,   8'd0};
        endcase
        return rgb;
    endfunction

endpackage

// ----- design/fehs_ram.sv -----
// ----------------------------------------------------------------------------
// fehs_ram: generic single-write, single-read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fehs_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/fehs_queue.sv -----
// ----------------------------------------------------------------------------
// fehs_queue: short first-in first-out queue
// Holds a few words between two parts so that each side stalls on its own.
// ----------------------------------------------------------------------------
module fehs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- design/fehs_front.sv -----
// ----------------------------------------------------------------------------
// fehs_front: input stage of the fire heat spread block
// Accepts words, clamps the image size, classifies the pixel and builds the
// source, upper and target addresses as a command word for the back end.
// ----------------------------------------------------------------------------
module fehs_front #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          opcode,
    input  logic [fehs_pkg::COORD_W-1:0]  column,
    input  logic [fehs_pkg::COORD_W-1:0]  row,
    input  logic [fehs_pkg::OFF_W-1:0]    random_offset,
    input  logic [fehs_pkg::CFG_W-1:0]    width_cfg,
    input  logic [fehs_pkg::CFG_W-1:0]    height_cfg,
    input  logic                          clearing,
    input  logic                          q_full,
    output logic                          q_push,
    output fehs_pkg::cmd_t                q_cmd
);

    localparam int CFG_W  = fehs_pkg::CFG_W;
    localparam int CALC_W = fehs_pkg::CALC_W;

    logic [CFG_W-1:0]            w_eff, h_eff;
    logic                        in_image, bottom, spread, accept;
    logic [fehs_pkg::OFF_W-1:0]  off_sat;

    logic                              s1_valid_reg, s1_valid_next;
    logic                              s1_in_image_reg, s1_spread_reg, s1_bottom_reg;
    logic [fehs_pkg::OFF_W-1:0]        s1_off_reg;
    logic [fehs_pkg::COORD_W-1:0]      s1_col_reg;
    logic [CFG_W-1:0]                  s1_w_reg;
    logic [fehs_pkg::PROD_W-1:0]       s1_prod_reg;
    logic [fehs_pkg::AREA_W-1:0]       s1_area_reg;

    logic [CALC_W-1:0] src, up, dst;

    always_comb
    begin
        if (width_cfg == '0)
        begin
            w_eff = CFG_W'(1);
        end
        else if (int'(width_cfg) > MAX_WIDTH)
        begin
            w_eff = CFG_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_cfg;
        end

        if (height_cfg < CFG_W'(2))
        begin
            h_eff = CFG_W'(2);
        end
        else if (int'(height_cfg) > MAX_HEIGHT)
        begin
            h_eff = CFG_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_cfg;
        end
    end

    assign in_image = ({1'b0, column} < w_eff) && ({1'b0, row} < h_eff);
    assign bottom   = ({1'b0, row} == (h_eff - CFG_W'(1)));
    assign spread   = (opcode == fehs_pkg::OP_SPREAD) && in_image && (row != '0);
    assign off_sat  = (random_offset > fehs_pkg::MAX_OFFSET) ? fehs_pkg::MAX_OFFSET
                                                             : random_offset;

    assign full   = clearing || (s1_valid_reg && q_full);
    assign accept = push && !full;
    assign q_push = s1_valid_reg && !q_full;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_in_image_reg <= in_image;
            s1_spread_reg   <= spread;
            s1_bottom_reg   <= bottom;
            s1_off_reg      <= off_sat;
            s1_col_reg      <= column;
            s1_w_reg        <= w_eff;
            s1_prod_reg     <= fehs_pkg::PROD_W'(row) * fehs_pkg::PROD_W'(w_eff);
            s1_area_reg     <= fehs_pkg::AREA_W'(w_eff) * fehs_pkg::AREA_W'(h_eff);
        end
    end

    assign src = CALC_W'(s1_prod_reg) + CALC_W'(s1_col_reg);
    assign up  = src - CALC_W'(s1_w_reg);
    assign dst = up + CALC_W'(s1_off_reg) + CALC_W'(1);

    always_comb
    begin
        q_cmd.in_image = s1_in_image_reg;
        q_cmd.spread   = s1_spread_reg;
        q_cmd.bottom   = s1_bottom_reg;
        q_cmd.off      = s1_off_reg;
        q_cmd.src      = src;
        q_cmd.up       = up;
        q_cmd.dst      = dst;
        q_cmd.dst_ok   = (dst < CALC_W'(s1_area_reg));
    end

endmodule

// ----- design/fehs_back.sv -----
// ----------------------------------------------------------------------------
// fehs_back: heat store and execution stage of the fire heat spread block
// Clears the store after reset, then reads each command's source pixel, for a
// spread command writes the spread heat, and queues the result word.
// ----------------------------------------------------------------------------
module fehs_back #(
    parameter int DEPTH = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  fehs_pkg::cmd_t                cmd,
    output logic                          cmd_pop,
    input  logic                          pop,
    output logic                          empty,
    output logic [fehs_pkg::HEAT_W-1:0]   heat,
    output fehs_pkg::back_status_t        status
);

    localparam int AW     = $clog2(DEPTH);
    localparam int HEAT_W = fehs_pkg::HEAT_W;

    fehs_pkg::back_state_t state_reg, state_next;
    logic [AW-1:0]         clr_addr_reg, clr_addr_next;
    fehs_pkg::cmd_t        cur_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [HEAT_W-1:0] ram_wdata;
    logic [HEAT_W-1:0] ram_rdata;

    logic              res_push, res_full;
    logic [HEAT_W-1:0] heat_cur;
    logic [HEAT_W:0]   heat_sum;
    logic [HEAT_W-1:0] heat_new;

    fehs_ram #(
        .WIDTH (HEAT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (AW'(cmd.src)),
        .rdata (ram_rdata)
    );

    fehs_queue #(
        .WIDTH (HEAT_W),
        .DEPTH (2)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (heat_cur),
        .pop   (pop),
        .rdata (heat),
        .full  (res_full),
        .empty (empty)
    );

    always_comb
    begin
        if (!cur_reg.in_image)
        begin
            heat_cur = fehs_pkg::COLD_HEAT;
        end
        else if (cur_reg.bottom)
        begin
            heat_cur = fehs_pkg::HOT_HEAT;
        end
        else
        begin
            heat_cur = ram_rdata;
        end
    end

    assign heat_sum = {1'b0, heat_cur} + (HEAT_W + 1)'(cur_reg.off);
    assign heat_new = (heat_sum > {1'b0, fehs_pkg::COLD_HEAT}) ? fehs_pkg::COLD_HEAT
                                                               : heat_sum[HEAT_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        cmd_pop       = 1'b0;
        res_push      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = clr_addr_reg;
        ram_wdata     = fehs_pkg::COLD_HEAT;
        case (state_reg)
            fehs_pkg::BK_CLEAR:
            begin
                ram_we        = 1'b1;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = fehs_pkg::BK_IDLE;
                end
            end
            fehs_pkg::BK_IDLE:
            begin
                if (cmd_valid && !res_full)
                begin
                    cmd_pop    = 1'b1;
                    state_next = fehs_pkg::BK_ACCESS;
                end
            end
            fehs_pkg::BK_ACCESS:
            begin
                res_push   = 1'b1;
                state_next = fehs_pkg::BK_IDLE;
                if (cur_reg.spread)
                begin
                    if (heat_cur >= fehs_pkg::COLD_HEAT)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(cur_reg.up);
                        ram_wdata = fehs_pkg::COLD_HEAT;
                    end
                    else if (cur_reg.dst_ok)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(cur_reg.dst);
                        ram_wdata = heat_new;
                    end
                end
            end
            default:
            begin
                state_next = fehs_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= fehs_pkg::BK_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cur_reg <= cmd;
        end
    end

    assign status.clearing = (state_reg == fehs_pkg::BK_CLEAR);
    assign status.res_push = res_push;
    assign status.res_full = res_full;

endmodule

// ----- design/fire_effect_heat_spread.sv -----
// ----------------------------------------------------------------------------
// fire_effect_heat_spread: flame heat map with spread and read words
// A word passes the front register, the command queue, the back end and the
// result queue. The back end takes a new word only once the last is done: it
// reads the heat store in its idle state and writes it in the access state.
// Reset: registers return to 256 x 256; the store is then swept to cold,
// one cell a cycle across all MAX_WIDTH*MAX_HEIGHT cells, with full held high.
// ----------------------------------------------------------------------------
module fire_effect_heat_spread #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            opcode,
    input  logic [fehs_pkg::COORD_W-1:0]    column,
    input  logic [fehs_pkg::COORD_W-1:0]    row,
    input  logic [fehs_pkg::OFF_W-1:0]      random_offset,
    output logic                            empty,
    input  logic                            pop,
    output logic [fehs_pkg::HEAT_W-1:0]     heat,
    output logic [fehs_pkg::COLOUR_W-1:0]   red,
    output logic [fehs_pkg::COLOUR_W-1:0]   green,
    output logic [fehs_pkg::COLOUR_W-1:0]   blue,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int CFG_W = fehs_pkg::CFG_W;

    logic [CFG_W-1:0]        width_reg, height_reg;
    logic                    cfg_write;
    fehs_pkg::reg_idx_t      cfg_idx;

    logic                    q_push, q_full, q_empty, cmd_pop;
    fehs_pkg::cmd_t          q_cmd_in, q_cmd_out;
    fehs_pkg::back_status_t  bk_status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = fehs_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= fehs_pkg::WIDTH_RESET;
            height_reg <= fehs_pkg::HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                fehs_pkg::REG_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                fehs_pkg::REG_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                default:              width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            fehs_pkg::REG_WIDTH:  prdata = {{(32 - CFG_W){1'b0}}, width_reg};
            fehs_pkg::REG_HEIGHT: prdata = {{(32 - CFG_W){1'b0}}, height_reg};
            default:              prdata = '0;
        endcase
    end

    fehs_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .column        (column),
        .row           (row),
        .random_offset (random_offset),
        .width_cfg     (width_reg),
        .height_cfg    (height_reg),
        .clearing      (bk_status.clearing),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_cmd_in)
    );

    fehs_queue #(
        .WIDTH ($bits(fehs_pkg::cmd_t)),
        .DEPTH (2)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_cmd_in),
        .pop   (cmd_pop),
        .rdata (q_cmd_out),
        .full  (q_full),
        .empty (q_empty)
    );

    fehs_back #(
        .DEPTH (MAX_WIDTH * MAX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_empty),
        .cmd       (q_cmd_out),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .heat      (heat),
        .status    (bk_status)
    );

    assign {red, green, blue} = fehs_pkg::palette(heat);

    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        bk_status.clearing |-> full)
        else $error("word accepted during store clear");

    a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
        bk_status.res_push |-> !bk_status.res_full)
        else $error("result pushed into full queue");

    a_pop_then_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> bk_status.res_push)
        else $error("command popped without a result");

    a_heat_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (heat <= fehs_pkg::COLD_HEAT))
        else $error("result heat out of range");

endmodule
